// ----- design/fqks_pkg.sv -----
package fqks_pkg;

	// default number of slots in the ring buffer
	localparam int DEPTH_DEF = 8;

	// capacity register value after reset
	localparam logic [3:0] CAP_RESET = 4'd5;

	// operation codes on the func field
	localparam logic [1:0] FUNC_ENQ    = 2'd0;
	localparam logic [1:0] FUNC_DEQ    = 2'd1;
	localparam logic [1:0] FUNC_SEARCH = 2'd2;
	localparam logic [1:0] FUNC_LIST   = 2'd3;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK,
		ST_FULL,
		ST_EMPTY,
		ST_NOTFOUND
	} status_t;

	// decoded operation carried in the command queue
	typedef enum logic [1:0] {
		OP_ENQ,
		OP_DEQ,
		OP_SEARCH,
		OP_LIST
	} op_t;

	// back end sequencer states
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_READ,
		BK_DEQ,
		BK_CHECK,
		BK_LIST
	} bk_state_t;

	// input item
	typedef struct packed {
		logic [1:0]         func;
		logic signed [31:0] date_value;
		logic signed [31:0] job_number;
	} req_t;

	// result item
	typedef struct packed {
		status_t            status;
		logic [3:0]         position;
		logic signed [31:0] entry_date;
		logic signed [31:0] entry_job;
		logic [3:0]         occupancy;
		logic               last;
	} rsp_t;

	// classified command between front and back
	typedef struct packed {
		op_t                op;
		logic signed [31:0] date_value;
		logic signed [31:0] job_number;
	} cmd_t;

endpackage

// ----- design/fqks_front.sv -----
module fqks_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  fqks_pkg::req_t req,
	output logic           cmd_valid,
	output fqks_pkg::cmd_t cmd,
	input  logic           cmd_pop
);
	import fqks_pkg::*;

	localparam int QD = 2;

	cmd_t       fifo_q [QD];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	cmd_t       dec;
	logic       push;

	// queue full holds off the input side
	assign req_stall = (fill_q == 2'(QD));
	assign push      = req_valid && !req_stall;
	assign cmd_valid = (fill_q != 2'd0);
	assign cmd       = fifo_q[rd_ptr_q];

	// classify the incoming item
	always_comb begin
		dec.date_value = req.date_value;
		dec.job_number = req.job_number;
		unique case (req.func)
			FUNC_ENQ:    dec.op = OP_ENQ;
			FUNC_DEQ:    dec.op = OP_DEQ;
			FUNC_SEARCH: dec.op = OP_SEARCH;
			FUNC_LIST:   dec.op = OP_LIST;
			default:     dec.op = OP_ENQ;
		endcase
	end

	// command storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= dec;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !cmd_pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (!push && cmd_pop) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

// ----- design/fqks_back.sv -----
module fqks_back #(
	parameter int DEPTH = fqks_pkg::DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  fqks_pkg::cmd_t cmd,
	output logic           cmd_pop,
	input  logic [3:0]     cap_limit,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output fqks_pkg::rsp_t rsp
);
	import fqks_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW = CW + 1;

	logic signed [31:0] date_mem [DEPTH];
	logic signed [31:0] job_mem [DEPTH];
	logic signed [31:0] date_rd_q;
	logic signed [31:0] job_rd_q;

	bk_state_t          state_q;
	bk_state_t          state_d;
	logic [AW-1:0]      head_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      idx_q;
	op_t                op_q;
	logic signed [31:0] key_q;
	rsp_t               rsp_q;
	logic               rsp_valid_q;

	rsp_t               res;
	logic               out_free;
	logic               full;
	logic               last_i;
	logic               hit;
	logic               out_load;
	logic               mem_we;
	logic               mem_re;
	logic               head_inc;
	logic               cnt_inc;
	logic               cnt_dec;
	logic               idx_inc;
	logic               idx_clr;
	logic [AW-1:0]      wr_addr;
	logic [AW-1:0]      rd_addr;
	logic [CW:0]        pos_w;
	logic [CW:0]        cnt_up_w;
	logic [CW:0]        cnt_dn_w;

	// ring slot of an offset from the head
	function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] h, input logic [CW-1:0] off);
		logic [SW-1:0] sum;
		sum = SW'(h) + SW'(off);
		if (sum >= SW'(DEPTH)) begin
			sum = sum - SW'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	// low four bits of a count
	function automatic logic [3:0] to_nib(input logic [CW:0] v);
		logic [CW+4:0] t;
		t = {4'b0000, v};
		return t[3:0];
	endfunction

	// derived values
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign full     = (cnt_q >= CW'(DEPTH)) ||
	                  ({4'b0000, cnt_q} >= {{CW{1'b0}}, cap_limit});
	assign pos_w    = {1'b0, idx_q} + {{CW{1'b0}}, 1'b1};
	assign cnt_up_w = {1'b0, cnt_q} + {{CW{1'b0}}, 1'b1};
	assign cnt_dn_w = {1'b0, cnt_q} - {{CW{1'b0}}, 1'b1};
	assign last_i   = (pos_w == {1'b0, cnt_q});
	assign hit      = (job_rd_q == key_q);
	assign wr_addr  = slot_of(head_q, cnt_q);
	assign rd_addr  = slot_of(head_q, idx_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid && out_free && cmd.op != OP_ENQ && cnt_q != '0) begin
					state_d = BK_READ;
				end
			end
			BK_READ: begin
				unique case (op_q)
					OP_DEQ:    state_d = BK_DEQ;
					OP_SEARCH: state_d = BK_CHECK;
					OP_LIST:   state_d = BK_LIST;
					default:   state_d = BK_IDLE;
				endcase
			end
			BK_DEQ: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			BK_CHECK: begin
				if (hit || last_i) begin
					if (out_free) begin
						state_d = BK_IDLE;
					end
				end else begin
					state_d = BK_READ;
				end
			end
			BK_LIST: begin
				if (out_free) begin
					state_d = last_i ? BK_IDLE : BK_READ;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		cmd_pop        = 1'b0;
		out_load       = 1'b0;
		mem_we         = 1'b0;
		mem_re         = 1'b0;
		head_inc       = 1'b0;
		cnt_inc        = 1'b0;
		cnt_dec        = 1'b0;
		idx_inc        = 1'b0;
		idx_clr        = 1'b0;
		res.status     = ST_OK;
		res.position   = 4'd0;
		res.entry_date = '0;
		res.entry_job  = '0;
		res.occupancy  = to_nib({1'b0, cnt_q});
		res.last       = 1'b1;
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid && out_free) begin
					cmd_pop = 1'b1;
					if (cmd.op == OP_ENQ) begin
						out_load = 1'b1;
						if (full) begin
							res.status = ST_FULL;
						end else begin
							mem_we        = 1'b1;
							cnt_inc       = 1'b1;
							res.occupancy = to_nib(cnt_up_w);
						end
					end else if (cnt_q == '0) begin
						out_load   = 1'b1;
						res.status = ST_EMPTY;
					end else begin
						idx_clr = 1'b1;
					end
				end
			end
			BK_READ: begin
				mem_re = 1'b1;
			end
			BK_DEQ: begin
				if (out_free) begin
					out_load       = 1'b1;
					head_inc       = 1'b1;
					cnt_dec        = 1'b1;
					res.entry_date = date_rd_q;
					res.entry_job  = job_rd_q;
					res.occupancy  = to_nib(cnt_dn_w);
				end
			end
			BK_CHECK: begin
				if (hit) begin
					out_load     = out_free;
					res.position = to_nib(pos_w);
				end else if (last_i) begin
					out_load   = out_free;
					res.status = ST_NOTFOUND;
				end else begin
					idx_inc = 1'b1;
				end
			end
			BK_LIST: begin
				if (out_free) begin
					out_load       = 1'b1;
					idx_inc        = !last_i;
					res.position   = to_nib(pos_w);
					res.entry_date = date_rd_q;
					res.entry_job  = job_rd_q;
					res.last       = last_i;
				end
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	// entry store write port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			date_mem[wr_addr] <= cmd.date_value;
			job_mem[wr_addr]  <= cmd.job_number;
		end
	end

	// entry store read port
	always_ff @(posedge clk) begin
		if (mem_re) begin
			date_rd_q <= date_mem[rd_addr];
			job_rd_q  <= job_mem[rd_addr];
		end
	end

	// search key and result payload
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			key_q <= cmd.job_number;
		end
		if (out_load) begin
			rsp_q <= res;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			head_q      <= '0;
			cnt_q       <= '0;
			idx_q       <= '0;
			op_q        <= OP_ENQ;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd_pop) begin
				op_q <= cmd.op;
			end
			if (head_inc) begin
				head_q <= (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
			end
			if (cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (cnt_dec) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (idx_clr) begin
				idx_q <= '0;
			end else if (idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// occupancy never passes the buffer size
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CW'(DEPTH))
		else $error("entry count beyond buffer size");

	// a read is always followed by its consuming state
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_READ |=>
		(state_q == BK_DEQ || state_q == BK_CHECK || state_q == BK_LIST))
		else $error("read not followed by a consuming state");

	// a pending result is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!rsp_valid_q || !rsp_stall))
		else $error("result register overwritten while stalled");

endmodule

// ----- design/fifo_queue_with_key_search_unit.sv -----
// enqueue and empty-queue results are registered straight from the popped command; dequeue reads
// the head slot (READ) and then loads the result (DEQ); search walks the slots, a READ then a CHECK per
// slot, until a hit or the last entry; list gives each entry by a READ then a LIST step
// the back sequencer walks the single-read-port entry store and takes no new item until it is through
// with the last; a 2-item command queue decouples input
// reset: asynchronous, clears queue, head, count and output valid; capacity returns to 5
module fifo_queue_with_key_search_unit #(
	parameter int DEPTH = fqks_pkg::DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  fqks_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output fqks_pkg::rsp_t rsp,
	input  logic           cfg_we,
	input  logic [3:0]     cfg_wdata
);
	import fqks_pkg::*;

	logic       cmd_valid;
	cmd_t       cmd;
	logic       cmd_pop;
	logic [3:0] cap_q;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// front: accept and classify
	fqks_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	// back: queue store and sequencer
	fqks_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.cap_limit (cap_q),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
